// File: sv/ppsd_pkg.sv
// Shared types, widths and register map for the positional PID servo drive.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ppsd_pkg;

    // Position sample width (4 to 16)
    localparam int POS_BITS     = 10;

    // Fixed configuration and result widths
    localparam int GAIN_W       = 16;
    localparam int DUTY_OUT_W   = 16;
    localparam int PID_OUT_W    = 32;
    localparam int Q_SHIFT      = 8;

    // Derived datapath widths
    localparam int ERR_W        = POS_BITS + 1;
    localparam int DELTA_W      = ERR_W + 1;
    localparam int INTEG_W      = 16;
    localparam int INTEG_ACC_W  = INTEG_W + 1;
    localparam int P_PROD_W     = GAIN_W + 1 + ERR_W;
    localparam int D_PROD_W     = GAIN_W + 1 + DELTA_W;
    localparam int I_PROD_W     = GAIN_W + 1 + INTEG_W;
    localparam int PROD_MAX_W   = (D_PROD_W > I_PROD_W) ? D_PROD_W : I_PROD_W;
    localparam int RAW_W        = PROD_MAX_W + 2;
    localparam int PID_W        = RAW_W - Q_SHIFT;
    localparam int DUTY_W       = PID_W + 2;

    // Conditional integration band: 1 < |error| < 10
    localparam logic signed [ERR_W-1:0] ERR_BAND_LO     = ERR_W'(1);
    localparam logic signed [ERR_W-1:0] ERR_BAND_HI     = ERR_W'(10);
    localparam logic signed [ERR_W-1:0] ERR_BAND_NEG_LO = -ERR_W'(1);
    localparam logic signed [ERR_W-1:0] ERR_BAND_NEG_HI = -ERR_W'(10);

    // Integral saturation limits
    localparam logic signed [INTEG_ACC_W-1:0] INTEG_POS_LIMIT = INTEG_ACC_W'(32767);
    localparam logic signed [INTEG_ACC_W-1:0] INTEG_NEG_LIMIT = -INTEG_ACC_W'(32767);

    // APB register map
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 5;

    typedef enum logic [2:0] {
        REG_TARGET_POSITION  = 3'd0,
        REG_P_GAIN           = 3'd1,
        REG_I_GAIN           = 3'd2,
        REG_D_GAIN           = 3'd3,
        REG_CENTER_DUTY      = 3'd4,
        REG_INVERT_DIRECTION = 3'd5,
        REG_DUTY_MIN         = 3'd6,
        REG_DUTY_MAX         = 3'd7
    } ppsd_reg_idx_t;

    // Configuration bundle handed from the register file to the datapath
    typedef struct packed {
        logic [POS_BITS-1:0]   target_position;
        logic [GAIN_W-1:0]     p_gain;
        logic [GAIN_W-1:0]     i_gain;
        logic [GAIN_W-1:0]     d_gain;
        logic [DUTY_OUT_W-1:0] center_duty;
        logic                  invert_direction;
        logic [DUTY_OUT_W-1:0] duty_min;
        logic [DUTY_OUT_W-1:0] duty_max;
    } ppsd_cfg_t;

endpackage

// File: sv/ppsd_core.sv
// PID datapath: error and integral state, three gain products, Q8.8 scaling,
// duty offset and clamp, between an input and a result register. Uses ppsd_pkg.
`timescale 1ns / 1ps

module ppsd_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ppsd_pkg::ppsd_cfg_t             cfg,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ppsd_pkg::POS_BITS-1:0]   measured_position,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ppsd_pkg::DUTY_OUT_W-1:0] duty_value,
    output logic signed [ppsd_pkg::PID_OUT_W-1:0] pid_term,
    output logic                            was_clamped
);
    import ppsd_pkg::*;

    // Controller state
    logic signed [INTEG_W-1:0]     integral_reg;
    logic signed [ERR_W-1:0]       prev_err_reg;

    // Register valids and enables
    logic s1_valid_reg, out_valid_reg;
    logic out_stage_ready;
    logic in_fire;

    // Input register payload
    logic signed [ERR_W-1:0]       s1_err_reg;
    logic signed [DELTA_W-1:0]     s1_delta_reg;
    logic signed [INTEG_W-1:0]     s1_integ_reg;

    // Output register
    logic [DUTY_OUT_W-1:0]         duty_reg;
    logic signed [PID_OUT_W-1:0]   pid_reg;
    logic                          clamped_reg;

    // Combinational values
    logic signed [ERR_W-1:0]       err;
    logic                          in_band;
    logic signed [INTEG_ACC_W-1:0] integ_acc;
    logic signed [INTEG_W-1:0]     integ_sat;
    logic signed [INTEG_W-1:0]     integral_next;
    logic signed [DELTA_W-1:0]     delta;
    logic signed [P_PROD_W-1:0]    p_prod;
    logic signed [D_PROD_W-1:0]    d_prod;
    logic signed [I_PROD_W-1:0]    i_prod;
    logic signed [RAW_W-1:0]       raw_sum;
    logic signed [PID_W-1:0]       pid_val;
    logic signed [DUTY_W-1:0]      center_ext;
    logic signed [DUTY_W-1:0]      min_ext;
    logic signed [DUTY_W-1:0]      max_ext;
    logic signed [DUTY_W-1:0]      duty_raw;
    logic [DUTY_OUT_W-1:0]         duty_next;
    logic                          clamped_next;

    // Ready chain: a register takes new data when empty or when it drains
    always_comb
    begin
        out_stage_ready = !out_valid_reg || out_ready;
        in_ready        = !s1_valid_reg || out_stage_ready;
        in_fire         = in_valid && in_ready;
    end

    // Error, conditional integration with saturation, derivative
    always_comb
    begin
        err = $signed({1'b0, cfg.target_position}) - $signed({1'b0, measured_position});
        in_band = ((err > ERR_BAND_LO) && (err < ERR_BAND_HI)) ||
                  ((err < ERR_BAND_NEG_LO) && (err > ERR_BAND_NEG_HI));
        integ_acc = INTEG_ACC_W'(integral_reg) + INTEG_ACC_W'(err);
        priority if (integ_acc > INTEG_POS_LIMIT)
            integ_sat = INTEG_W'(INTEG_POS_LIMIT);
        else if (integ_acc < INTEG_NEG_LIMIT)
            integ_sat = INTEG_W'(INTEG_NEG_LIMIT);
        else
            integ_sat = INTEG_W'(integ_acc);
        integral_next = in_band ? integ_sat : integral_reg;
        delta = DELTA_W'(err) - DELTA_W'(prev_err_reg);
    end

    // Update controller state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            prev_err_reg <= '0;
        end
        else if (in_fire)
        begin
            integral_reg <= integral_next;
            prev_err_reg <= err;
        end
    end

    // Three gain products, their sum and the Q8.8 shift
    always_comb
    begin
        p_prod  = $signed({1'b0, cfg.p_gain}) * s1_err_reg;
        d_prod  = $signed({1'b0, cfg.d_gain}) * s1_delta_reg;
        i_prod  = $signed({1'b0, cfg.i_gain}) * s1_integ_reg;
        raw_sum = RAW_W'(p_prod) + RAW_W'(d_prod) + RAW_W'(i_prod);
        pid_val = raw_sum[RAW_W-1:Q_SHIFT];
    end

    // Offset from center and clamp, max test first
    always_comb
    begin
        center_ext = DUTY_W'($signed({1'b0, cfg.center_duty}));
        min_ext    = DUTY_W'($signed({1'b0, cfg.duty_min}));
        max_ext    = DUTY_W'($signed({1'b0, cfg.duty_max}));
        if (cfg.invert_direction)
            duty_raw = center_ext - DUTY_W'(pid_val);
        else
            duty_raw = center_ext + DUTY_W'(pid_val);
        priority if (duty_raw >= max_ext)
        begin
            duty_next    = cfg.duty_max;
            clamped_next = 1'b1;
        end
        else if (duty_raw <= min_ext)
        begin
            duty_next    = cfg.duty_min;
            clamped_next = 1'b1;
        end
        else
        begin
            duty_next    = DUTY_OUT_W'(duty_raw);
            clamped_next = 1'b0;
        end
    end

    // Advance register valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (out_stage_ready)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Load register payloads
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_err_reg   <= err;
            s1_delta_reg <= delta;
            s1_integ_reg <= integral_next;
        end
        if (out_stage_ready && s1_valid_reg)
        begin
            duty_reg    <= duty_next;
            pid_reg     <= PID_OUT_W'(pid_val);
            clamped_reg <= clamped_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign duty_value  = duty_reg;
    assign pid_term    = pid_reg;
    assign was_clamped = clamped_reg;

    // Integral never leaves its saturation band
    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        (integral_reg <= INTEG_W'(INTEG_POS_LIMIT)) &&
        (integral_reg >= INTEG_W'(INTEG_NEG_LIMIT)))
        else $error("integral state out of range");

    // State moves only with an accepted request
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(integral_reg) && $stable(prev_err_reg))
        else $error("controller state changed without a request");

    // An accepted request always lands in the input register
    a_s1_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted request lost at the input register");

    // An unclamped duty lies strictly inside the limits
    a_clamp_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !clamped_reg) |->
        (duty_reg > cfg.duty_min) && (duty_reg < cfg.duty_max))
        else $error("duty outside limits without clamp flag");

endmodule

// File: sv/positional_pid_servo_drive.sv
// Top level of the positional PID servo drive: APB register file and the
// request channels around the PID datapath. Uses ppsd_pkg and ppsd_core.
`timescale 1ns / 1ps

// Channel         Direction  Handshake                Payload
// position in     in         in_valid / in_ready      measured_position
// duty out        out        out_valid / out_ready    duty_value, pid_term, was_clamped
// registers       in/out     psel, penable, pready    paddr, pwrite, pwdata, prdata
//
// One request is accepted per cycle while in_ready is high. The error, integral
// and derivative are latched in the input register at acceptance; the result
// register is loaded from it after one pass of products, sum, shift, offset and
// clamp, once it is free, and out_valid rises when it is loaded.
// Reset loads the register defaults and clears the integral and last error.
// A stalled output holds its result; input stays ready until both registers fill.

module positional_pid_servo_drive (
    input  logic                            clk,
    input  logic                            rst_n,
    // APB register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ppsd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ppsd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ppsd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // Position requests
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ppsd_pkg::POS_BITS-1:0]   measured_position,
    // Duty results
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ppsd_pkg::DUTY_OUT_W-1:0] duty_value,
    output logic signed [ppsd_pkg::PID_OUT_W-1:0] pid_term,
    output logic                            was_clamped
);
    import ppsd_pkg::*;

    ppsd_cfg_t     cfg_reg;
    ppsd_reg_idx_t reg_idx;
    logic          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = ppsd_reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Write registers in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_position  <= POS_BITS'(512);
            cfg_reg.p_gain           <= GAIN_W'(768);
            cfg_reg.i_gain           <= GAIN_W'(13);
            cfg_reg.d_gain           <= GAIN_W'(33280);
            cfg_reg.center_duty      <= DUTY_OUT_W'(750);
            cfg_reg.invert_direction <= 1'b0;
            cfg_reg.duty_min         <= DUTY_OUT_W'(500);
            cfg_reg.duty_max         <= DUTY_OUT_W'(1000);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_TARGET_POSITION:  cfg_reg.target_position  <= pwdata[POS_BITS-1:0];
                REG_P_GAIN:           cfg_reg.p_gain           <= pwdata[GAIN_W-1:0];
                REG_I_GAIN:           cfg_reg.i_gain           <= pwdata[GAIN_W-1:0];
                REG_D_GAIN:           cfg_reg.d_gain           <= pwdata[GAIN_W-1:0];
                REG_CENTER_DUTY:      cfg_reg.center_duty      <= pwdata[DUTY_OUT_W-1:0];
                REG_INVERT_DIRECTION: cfg_reg.invert_direction <= pwdata[0];
                REG_DUTY_MIN:         cfg_reg.duty_min         <= pwdata[DUTY_OUT_W-1:0];
                REG_DUTY_MAX:         cfg_reg.duty_max         <= pwdata[DUTY_OUT_W-1:0];
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_idx)
            REG_TARGET_POSITION:  prdata = APB_DATA_W'(cfg_reg.target_position);
            REG_P_GAIN:           prdata = APB_DATA_W'(cfg_reg.p_gain);
            REG_I_GAIN:           prdata = APB_DATA_W'(cfg_reg.i_gain);
            REG_D_GAIN:           prdata = APB_DATA_W'(cfg_reg.d_gain);
            REG_CENTER_DUTY:      prdata = APB_DATA_W'(cfg_reg.center_duty);
            REG_INVERT_DIRECTION: prdata = APB_DATA_W'(cfg_reg.invert_direction);
            REG_DUTY_MIN:         prdata = APB_DATA_W'(cfg_reg.duty_min);
            REG_DUTY_MAX:         prdata = APB_DATA_W'(cfg_reg.duty_max);
        endcase
    end

    ppsd_core u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .measured_position (measured_position),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .duty_value        (duty_value),
        .pid_term          (pid_term),
        .was_clamped       (was_clamped)
    );

endmodule
